// ===== hdl/rvt_pkg.sv =====
// ----------------------------------------------------------------------------
// rvt_pkg: shared types and constants of the ray voxel traversal block
// Holds the fixed-point formats, the controller states, the datapath
// commands and the status bundle that ties controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rvt_pkg;

   // Coordinates and coordinate differences, wide enough for the box bounds.
   localparam int CW = 40;
   typedef logic signed [CW-1:0] coord_type;

   // Alpha values are signed Q2.30.
   typedef logic signed [31:0] alpha_type;
   localparam alpha_type ONE_Q30 = 32'sh4000_0000;
   localparam alpha_type Q30_MAX = 32'sh7fff_ffff;
   localparam alpha_type Q30_MIN = 32'sh8000_0000;

   // Voxel coordinates: signed so that a step out of the box shows.
   localparam int POS_W = 6;
   localparam int IDX_W = 4;
   typedef logic signed [POS_W-1:0] pos_type;

   localparam int MAX_RESULTS = 48;
   localparam int CNT_W = 6;

   // Iterative divider: quotient bits and magnitude width.
   localparam int DIV_W = 40;
   localparam int Q_W = 31;
   localparam int DIV_CNT_W = 5;

   // Square root of the sum of squares.
   localparam int RAD_W = 66;
   localparam int ROOT_W = 33;
   localparam int REM_W = 35;
   localparam int SQRT_CNT_W = 6;

   // Register map, indexed by paddr[4:2].
   localparam logic [2:0] REG_LOW_X  = 3'd0;
   localparam logic [2:0] REG_LOW_Y  = 3'd1;
   localparam logic [2:0] REG_LOW_Z  = 3'd2;
   localparam logic [2:0] REG_SIZE_X = 3'd3;
   localparam logic [2:0] REG_SIZE_Y = 3'd4;
   localparam logic [2:0] REG_SIZE_Z = 3'd5;
   localparam logic [2:0] REG_TOL    = 3'd6;

   typedef struct packed {
      logic [2:0][31:0] low_plane;
      logic [2:0][30:0] voxel_size;
      logic [15:0]      tolerance;
   } cfg_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CHECK,
      ST_AMIN_GO,
      ST_AMIN_WAIT,
      ST_AMAX_GO,
      ST_AMAX_WAIT,
      ST_BOUND,
      ST_DA_GO,
      ST_DA_WAIT,
      ST_SQ,
      ST_POINT,
      ST_IDX,
      ST_AD_GO,
      ST_AD_WAIT,
      ST_AD_FIX,
      ST_SQRT_GO,
      ST_SQRT_RUN,
      ST_W_SEL,
      ST_W_MUL,
      ST_W_OUT,
      ST_MISS
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_MIN_GO,
      OP_MIN_CAP,
      OP_MAX_GO,
      OP_MAX_CAP,
      OP_DA_GO,
      OP_DA_CAP,
      OP_SQ,
      OP_POINT,
      OP_IDX,
      OP_AD_GO,
      OP_AD_CAP,
      OP_AD_FIX,
      OP_SQRT_GO,
      OP_SQRT_RUN,
      OP_W_SEL,
      OP_W_MUL,
      OP_W_OUT,
      OP_MISS
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] axis;
   } cmd_type;

   typedef struct packed {
      logic canc;
      logic outside;
      logic empty;
      logic div_done;
      logic idx_done;
      logic sqrt_done;
      logic walk_last;
   } status_type;

   // Clamp a 33-bit sum to the Q2.30 range.
   function automatic alpha_type sat_q30(input logic signed [32:0] v);
      alpha_type r;
      if (v > 33'sh0_7fff_ffff) begin
         r = Q30_MAX;
      end else if (v < -33'sh0_8000_0000) begin
         r = Q30_MIN;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/ray_voxel_traversal.sv =====
// ----------------------------------------------------------------------------
// ray_voxel_traversal: Siddon-style voxel walk of one 3D line segment
// Clips a Q16.16 segment to the voxel box and emits, voxel by voxel, the
// linear index and the path length inside that voxel.
// ----------------------------------------------------------------------------
// Order of work: clipping first, then per-axis setup and the square root, and
// then one result beat per voxel; a missed segment gives its beat earlier.
// Throughput: one segment at a time; start is taken only while busy is low.
// The 31-step shared divider and the 33-step square root set the setup time.
// Result beats are one-cycle strobes; the receiver cannot stall them.
// Reset (synchronous, active high) returns to idle and loads register defaults.
`default_nettype none

module ray_voxel_traversal #(
   parameter int SIZE_X = 16,
   parameter int SIZE_Y = 16,
   parameter int SIZE_Z = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // Segment command channel.
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [31:0] req_start_x,
   input  wire logic signed [31:0] req_start_y,
   input  wire logic signed [31:0] req_start_z,
   input  wire logic signed [31:0] req_end_x,
   input  wire logic signed [31:0] req_end_y,
   input  wire logic signed [31:0] req_end_z,
   // Result channel.
   output logic                    rsp_valid,
   output logic [11:0]             rsp_voxel_index,
   output logic [31:0]             rsp_path_length,
   output logic                    rsp_hit,
   output logic                    rsp_last,
   // Register port.
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [4:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   // Configuration registers. They are to be written only while the block is idle; the block does not enforce it.
   logic [31:0] low_x_ff, low_y_ff, low_z_ff;
   logic [30:0] vsize_x_ff, vsize_y_ff, vsize_z_ff;
   logic [15:0] tol_ff;
   logic        wr_en;
   logic [2:0]  reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;
   assign reg_sel = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         low_x_ff   <= '0;
         low_y_ff   <= '0;
         low_z_ff   <= '0;
         vsize_x_ff <= 31'd65536;
         vsize_y_ff <= 31'd65536;
         vsize_z_ff <= 31'd65536;
         tol_ff     <= 16'd1;
      end else if (wr_en) begin
         unique case (reg_sel)
            rvt_pkg::REG_LOW_X:  low_x_ff   <= pwdata;
            rvt_pkg::REG_LOW_Y:  low_y_ff   <= pwdata;
            rvt_pkg::REG_LOW_Z:  low_z_ff   <= pwdata;
            rvt_pkg::REG_SIZE_X: vsize_x_ff <= pwdata[30:0];
            rvt_pkg::REG_SIZE_Y: vsize_y_ff <= pwdata[30:0];
            rvt_pkg::REG_SIZE_Z: vsize_z_ff <= pwdata[30:0];
            rvt_pkg::REG_TOL:    tol_ff     <= pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      unique case (reg_sel)
         rvt_pkg::REG_LOW_X:  prdata = low_x_ff;
         rvt_pkg::REG_LOW_Y:  prdata = low_y_ff;
         rvt_pkg::REG_LOW_Z:  prdata = low_z_ff;
         rvt_pkg::REG_SIZE_X: prdata = {1'b0, vsize_x_ff};
         rvt_pkg::REG_SIZE_Y: prdata = {1'b0, vsize_y_ff};
         rvt_pkg::REG_SIZE_Z: prdata = {1'b0, vsize_z_ff};
         rvt_pkg::REG_TOL:    prdata = {16'b0, tol_ff};
         default:             prdata = '0;
      endcase
   end

   rvt_pkg::cfg_type cfg;
   always_comb begin
      cfg.low_plane[0]  = low_x_ff;
      cfg.low_plane[1]  = low_y_ff;
      cfg.low_plane[2]  = low_z_ff;
      cfg.voxel_size[0] = vsize_x_ff;
      cfg.voxel_size[1] = vsize_y_ff;
      cfg.voxel_size[2] = vsize_z_ff;
      cfg.tolerance     = tol_ff;
   end

   // The controller steps the datapath through clipping, per-axis setup,
   // the square root of the segment length and the voxel walk.
   rvt_pkg::cmd_type    cmd;
   rvt_pkg::status_type status;

   rvt_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   rvt_dp #(
      .SIZE_X (SIZE_X),
      .SIZE_Y (SIZE_Y),
      .SIZE_Z (SIZE_Z)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_start_x     (req_start_x),
      .req_start_y     (req_start_y),
      .req_start_z     (req_start_z),
      .req_end_x       (req_end_x),
      .req_end_y       (req_end_y),
      .req_end_z       (req_end_z),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_voxel_index (rsp_voxel_index),
      .rsp_path_length (rsp_path_length),
      .rsp_hit         (rsp_hit),
      .rsp_last        (rsp_last)
   );

   // A miss beat is always a lone, final, all-zero beat.
   a_miss_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_last && rsp_voxel_index == '0 &&
                                   rsp_path_length == '0))
      else $error("miss beat is malformed");

   // An accepted segment makes the block busy on the next cycle.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("segment accepted but block not busy");

   // Voxel indices stay inside the box.
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> ({1'b0, rsp_voxel_index} <
                                  13'(SIZE_X * SIZE_Y * SIZE_Z)))
      else $error("voxel index outside the box");

endmodule

`default_nettype wire

// ===== hdl/rvt_div.sv =====
// ----------------------------------------------------------------------------
// rvt_div: iterative Q2.30 divider
// Computes (a << 30) / d one quotient bit per cycle and flags a >= 2d.
// ----------------------------------------------------------------------------
`default_nettype none

module rvt_div (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           go,
   input  wire logic [rvt_pkg::DIV_W-1:0]      dividend,
   input  wire logic [rvt_pkg::DIV_W-1:0]      divisor,
   output logic                                done,
   output logic [rvt_pkg::Q_W-1:0]             quotient,
   output logic                                overflow
);

   logic                            busy_ff, busy_in;
   logic [rvt_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [rvt_pkg::DIV_W:0]         rem_ff, rem_in;
   logic [rvt_pkg::DIV_W-1:0]       den_ff, den_in;
   logic [rvt_pkg::Q_W-1:0]         q_ff, q_in;
   logic                            ovf_ff, ovf_in;
   logic [rvt_pkg::DIV_W:0]         diff;
   logic                            ge;

   assign ge   = rem_ff >= {1'b0, den_ff};
   assign diff = ge ? rem_ff - {1'b0, den_ff} : rem_ff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      ovf_in  = ovf_ff;
      if (go) begin
         busy_in = 1'b1;
         cnt_in  = rvt_pkg::DIV_CNT_W'(rvt_pkg::Q_W);
         rem_in  = {1'b0, dividend};
         den_in  = divisor;
         ovf_in  = {1'b0, dividend} >= {divisor, 1'b0};
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            q_in   = {q_ff[rvt_pkg::Q_W-2:0], ge};
            rem_in = {diff[rvt_pkg::DIV_W-1:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
      ovf_ff <= ovf_in;
   end

   assign done     = busy_ff && (cnt_ff == '0);
   assign quotient = q_ff;
   assign overflow = ovf_ff;

endmodule

`default_nettype wire

// ===== hdl/rvt_dp.sv =====
// ----------------------------------------------------------------------------
// rvt_dp: datapath of the ray voxel traversal block
// Per-axis registers, clipping, start voxel search, square root and the
// voxel walk, each step driven by a command from the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module rvt_dp #(
   parameter int SIZE_X = 16,
   parameter int SIZE_Y = 16,
   parameter int SIZE_Z = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rvt_pkg::cfg_type     cfg,
   input  wire logic signed [31:0]   req_start_x,
   input  wire logic signed [31:0]   req_start_y,
   input  wire logic signed [31:0]   req_start_z,
   input  wire logic signed [31:0]   req_end_x,
   input  wire logic signed [31:0]   req_end_y,
   input  wire logic signed [31:0]   req_end_z,
   input  wire rvt_pkg::cmd_type     cmd,
   output rvt_pkg::status_type       status,
   output logic                      rsp_valid,
   output logic [11:0]               rsp_voxel_index,
   output logic [31:0]               rsp_path_length,
   output logic                      rsp_hit,
   output logic                      rsp_last
);

   localparam int CW = rvt_pkg::CW;
   localparam int REM_W_P2 = rvt_pkg::REM_W + 2;

   // Per-axis state.
   rvt_pkg::coord_type s_ff[3], diff_ff[3], lo_ff[3], hi_ff[3];
   logic [30:0]        vs_ff[3];
   logic               canc_ff[3];
   rvt_pkg::alpha_type da_ff[3], ad_ff[3];
   rvt_pkg::pos_type   pos_ff[3];

   rvt_pkg::alpha_type emin_ff, emax_ff, prev_ff, next_ff;
   logic [63:0]        sq_ff;
   logic [62:0]        prod_ff;
   logic [65:0]        sum_ff;
   rvt_pkg::coord_type point_ff, base_ff, nxt_ff;
   logic [3:0]         k_ff;
   logic               neg_ff;

   logic [rvt_pkg::RAD_W-1:0]      rad_ff;
   logic [rvt_pkg::REM_W-1:0]      rem_ff;
   logic [rvt_pkg::ROOT_W-1:0]     root_ff;
   logic [rvt_pkg::SQRT_CNT_W-1:0] sq_cnt_ff;

   logic [30:0]                step_ff;
   logic [60:0]                plo_ff;
   logic [33:0]                phi_ff;
   logic [rvt_pkg::CNT_W-1:0]  cnt_ff;

   logic        rsp_valid_ff, rsp_hit_ff, rsp_last_ff;
   logic [11:0] rsp_index_ff;
   logic [31:0] rsp_len_ff;

   // Load lanes.
   logic signed [31:0] in_s[3], in_e[3];
   int                 size_a[3];

   always_comb begin
      in_s[0]   = req_start_x;
      in_s[1]   = req_start_y;
      in_s[2]   = req_start_z;
      in_e[0]   = req_end_x;
      in_e[1]   = req_end_y;
      in_e[2]   = req_end_z;
      size_a[0] = SIZE_X;
      size_a[1] = SIZE_Y;
      size_a[2] = SIZE_Z;
   end

   rvt_pkg::coord_type ld_s[3], ld_diff[3], ld_lo[3], ld_hi[3];
   logic [30:0]        ld_vs[3];
   logic               ld_canc[3];
   logic [CW-1:0]      ld_mag[3];
   rvt_pkg::coord_type tol_c;

   assign tol_c = $signed({{(CW-16){1'b0}}, cfg.tolerance});

   always_comb begin
      for (int d = 0; d < 3; d++) begin
         ld_s[d]    = CW'(in_s[d]);
         ld_diff[d] = CW'(in_e[d]) - CW'(in_s[d]);
         ld_mag[d]  = ld_diff[d][CW-1] ? CW'(-ld_diff[d]) : CW'(ld_diff[d]);
         ld_vs[d]   = (cfg.voxel_size[d] == '0) ? 31'd1 : cfg.voxel_size[d];
         ld_lo[d]   = CW'($signed(cfg.low_plane[d]));
         ld_hi[d]   = ld_lo[d] + $signed(CW'(size_a[d]) * CW'(ld_vs[d]));
         ld_canc[d] = ld_mag[d] <= CW'(cfg.tolerance);
      end
   end

   // Current-axis selection.
   rvt_pkg::coord_type cur_s, cur_diff, cur_lo, cur_hi;
   logic [30:0]        cur_vs;
   logic               cur_canc;
   rvt_pkg::alpha_type cur_da, cur_ad;
   logic [4:0]         cur_size;

   always_comb begin
      unique case (cmd.axis)
         2'd1: begin
            cur_s = s_ff[1]; cur_diff = diff_ff[1]; cur_lo = lo_ff[1]; cur_hi = hi_ff[1];
            cur_vs = vs_ff[1]; cur_canc = canc_ff[1]; cur_da = da_ff[1]; cur_ad = ad_ff[1];
            cur_size = 5'(SIZE_Y);
         end
         2'd2: begin
            cur_s = s_ff[2]; cur_diff = diff_ff[2]; cur_lo = lo_ff[2]; cur_hi = hi_ff[2];
            cur_vs = vs_ff[2]; cur_canc = canc_ff[2]; cur_da = da_ff[2]; cur_ad = ad_ff[2];
            cur_size = 5'(SIZE_Z);
         end
         default: begin
            cur_s = s_ff[0]; cur_diff = diff_ff[0]; cur_lo = lo_ff[0]; cur_hi = hi_ff[0];
            cur_vs = vs_ff[0]; cur_canc = canc_ff[0]; cur_da = da_ff[0]; cur_ad = ad_ff[0];
            cur_size = 5'(SIZE_X);
         end
      endcase
   end

   logic [31:0] cur_m;
   logic        cur_dirpos;
   assign cur_m      = cur_diff[CW-1] ? 32'(-cur_diff) : cur_diff[31:0];
   assign cur_dirpos = !cur_canc && !cur_diff[CW-1] && (cur_diff != '0);

   // Divider front end: signed numerator over signed difference, or the
   // voxel size over the difference magnitude for the alpha step.
   rvt_pkg::coord_type    div_num;
   logic [CW-1:0]         div_a, div_d;
   logic                  div_go, div_neg, div_done, div_ovf;
   logic [rvt_pkg::Q_W-1:0] div_q;
   rvt_pkg::alpha_type    div_res;

   always_comb begin
      priority case (cmd.op)
         rvt_pkg::OP_MIN_GO: div_num = (cur_dirpos ? cur_lo : cur_hi) - cur_s;
         rvt_pkg::OP_MAX_GO: div_num = (cur_dirpos ? cur_hi : cur_lo) - cur_s;
         default:            div_num = base_ff - cur_s;
      endcase
      if (cmd.op == rvt_pkg::OP_DA_GO) begin
         div_a   = CW'(cur_vs);
         div_d   = (cur_m == '0) ? CW'(1) : CW'(cur_m);
         div_neg = 1'b0;
      end else begin
         div_a   = div_num[CW-1] ? CW'(-div_num) : CW'(div_num);
         div_d   = CW'(cur_m);
         div_neg = div_num[CW-1] != cur_diff[CW-1];
      end
   end

   assign div_go = (cmd.op == rvt_pkg::OP_MIN_GO) || (cmd.op == rvt_pkg::OP_MAX_GO) ||
                   (cmd.op == rvt_pkg::OP_DA_GO) ||
                   ((cmd.op == rvt_pkg::OP_AD_GO) && !cur_canc);

   rvt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go),
      .dividend (div_a),
      .divisor  (div_d),
      .done     (div_done),
      .quotient (div_q),
      .overflow (div_ovf)
   );

   always_comb begin
      if (div_ovf) begin
         div_res = neg_ff ? rvt_pkg::Q30_MIN : rvt_pkg::Q30_MAX;
      end else if (neg_ff) begin
         div_res = -$signed({1'b0, div_q});
      end else begin
         div_res = $signed({1'b0, div_q});
      end
   end

   // Start voxel search.
   logic idx_cont;
   assign idx_cont = (k_ff < 4'(cur_size - 5'd1)) && (point_ff >= nxt_ff);

   logic [32:0]        off;
   rvt_pkg::coord_type point_new;
   assign off       = prod_ff[62:30];
   assign point_new = cur_diff[CW-1] ? cur_s - CW'(off) : cur_s + CW'(off);

   // Square root step, two radicand bits per cycle.
   logic [REM_W_P2-1:0] rem_t, trial;
   logic                sq_ge;
   assign rem_t = {rem_ff, rad_ff[rvt_pkg::RAD_W-1 -: 2]};
   assign trial = REM_W_P2'({root_ff, 2'b01});
   assign sq_ge = rem_t >= trial;

   // Walk.
   rvt_pkg::alpha_type w_next;
   always_comb begin
      w_next = emax_ff;
      for (int d = 0; d < 3; d++) begin
         if (ad_ff[d] < w_next) w_next = ad_ff[d];
      end
   end

   logic [34:0] w_len;
   assign w_len = 35'(phi_ff) + 35'(plo_ff[60:30]);

   rvt_pkg::alpha_type up_ad[3];
   rvt_pkg::pos_type   up_pos[3];
   logic               oob;

   always_comb begin
      logic signed [32:0] g;
      logic [32:0]        gap;
      oob = 1'b0;
      for (int d = 0; d < 3; d++) begin
         g   = 33'(ad_ff[d]) - 33'(next_ff);
         gap = g[32] ? 33'(-g) : 33'(g);
         up_ad[d]  = ad_ff[d];
         up_pos[d] = pos_ff[d];
         if ((gap == '0) || (gap < 33'(cfg.tolerance))) begin
            up_ad[d]  = rvt_pkg::sat_q30(33'(ad_ff[d]) + 33'(da_ff[d]));
            up_pos[d] = (canc_ff[d] || diff_ff[d][CW-1]) ? pos_ff[d] - 1'b1
                                                         : pos_ff[d] + 1'b1;
         end
         if ((up_pos[d] < 0) ||
             (up_pos[d] > rvt_pkg::POS_W'(size_a[d] - 1))) begin
            oob = 1'b1;
         end
      end
   end

   logic [11:0] w_index;
   assign w_index = 12'(pos_ff[0][rvt_pkg::IDX_W-1:0]) +
                    12'(pos_ff[1][rvt_pkg::IDX_W-1:0]) * 12'(SIZE_X) +
                    12'(pos_ff[2][rvt_pkg::IDX_W-1:0]) * 12'(SIZE_X * SIZE_Y);

   always_comb begin
      status.canc      = cur_canc;
      status.outside   = (cur_s < cur_lo) || (cur_s > cur_hi);
      status.empty     = emin_ff >= emax_ff;
      status.div_done  = div_done;
      status.idx_done  = !idx_cont;
      status.sqrt_done = sq_cnt_ff == '0;
      status.walk_last = oob || (next_ff >= emax_ff) ||
                         (cnt_ff == rvt_pkg::CNT_W'(rvt_pkg::MAX_RESULTS - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (cmd.op == rvt_pkg::OP_W_OUT) || (cmd.op == rvt_pkg::OP_MISS);
      end

      if (div_go) begin
         neg_ff <= div_neg;
      end

      unique case (cmd.op)
         rvt_pkg::OP_LOAD: begin
            for (int d = 0; d < 3; d++) begin
               s_ff[d]    <= ld_s[d];
               diff_ff[d] <= ld_canc[d] ? tol_c : ld_diff[d];
               lo_ff[d]   <= ld_lo[d];
               hi_ff[d]   <= ld_hi[d];
               vs_ff[d]   <= ld_vs[d];
               canc_ff[d] <= ld_canc[d];
            end
            emin_ff <= '0;
            emax_ff <= rvt_pkg::ONE_Q30;
         end
         rvt_pkg::OP_MIN_CAP: begin
            if (div_done && (div_res > emin_ff)) emin_ff <= div_res;
         end
         rvt_pkg::OP_MAX_CAP: begin
            if (div_done && (div_res < emax_ff)) emax_ff <= div_res;
         end
         rvt_pkg::OP_DA_CAP: begin
            if (div_done) da_ff[cmd.axis] <= (div_res == '0) ? 32'sd1 : div_res;
         end
         rvt_pkg::OP_SQ: begin
            sq_ff   <= 64'(cur_m) * 64'(cur_m);
            prod_ff <= 63'(cur_m) * 63'(emin_ff[30:0]);
         end
         rvt_pkg::OP_POINT: begin
            sum_ff   <= ((cmd.axis == 2'd0) ? '0 : sum_ff) + 66'(sq_ff);
            point_ff <= point_new;
            base_ff  <= cur_lo;
            nxt_ff   <= cur_lo + CW'(cur_vs);
            k_ff     <= '0;
         end
         rvt_pkg::OP_IDX: begin
            if (idx_cont) begin
               k_ff    <= k_ff + 1'b1;
               base_ff <= nxt_ff;
               nxt_ff  <= nxt_ff + CW'(cur_vs);
            end
         end
         rvt_pkg::OP_AD_GO: begin
            if (cur_canc) ad_ff[cmd.axis] <= rvt_pkg::ONE_Q30;
         end
         rvt_pkg::OP_AD_CAP: begin
            if (div_done) ad_ff[cmd.axis] <= div_res;
         end
         rvt_pkg::OP_AD_FIX: begin
            if (cur_dirpos) ad_ff[cmd.axis] <= rvt_pkg::sat_q30(33'(cur_ad) + 33'(cur_da));
            pos_ff[cmd.axis] <= rvt_pkg::POS_W'(k_ff);
         end
         rvt_pkg::OP_SQRT_GO: begin
            rad_ff    <= sum_ff;
            rem_ff    <= '0;
            root_ff   <= '0;
            sq_cnt_ff <= rvt_pkg::SQRT_CNT_W'(rvt_pkg::ROOT_W);
            prev_ff   <= emin_ff;
            cnt_ff    <= '0;
         end
         rvt_pkg::OP_SQRT_RUN: begin
            if (sq_cnt_ff != '0) begin
               rem_ff    <= sq_ge ? rvt_pkg::REM_W'(rem_t - trial) : rvt_pkg::REM_W'(rem_t);
               root_ff   <= {root_ff[rvt_pkg::ROOT_W-2:0], sq_ge};
               rad_ff    <= {rad_ff[rvt_pkg::RAD_W-3:0], 2'b00};
               sq_cnt_ff <= sq_cnt_ff - 1'b1;
            end
         end
         rvt_pkg::OP_W_SEL: begin
            next_ff <= w_next;
            step_ff <= (w_next > prev_ff) ? 31'(w_next - prev_ff) : '0;
         end
         rvt_pkg::OP_W_MUL: begin
            plo_ff <= 61'(step_ff) * 61'(root_ff[29:0]);
            phi_ff <= 34'(step_ff) * 34'(root_ff[32:30]);
         end
         rvt_pkg::OP_W_OUT: begin
            rsp_index_ff <= w_index;
            rsp_len_ff   <= (w_len[34:32] != '0) ? 32'hffff_ffff : w_len[31:0];
            rsp_hit_ff   <= 1'b1;
            rsp_last_ff  <= status.walk_last;
            for (int d = 0; d < 3; d++) begin
               ad_ff[d]  <= up_ad[d];
               pos_ff[d] <= up_pos[d];
            end
            prev_ff <= next_ff;
            cnt_ff  <= cnt_ff + 1'b1;
         end
         rvt_pkg::OP_MISS: begin
            rsp_index_ff <= '0;
            rsp_len_ff   <= '0;
            rsp_hit_ff   <= 1'b0;
            rsp_last_ff  <= 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_voxel_index = rsp_index_ff;
   assign rsp_path_length = rsp_len_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

`default_nettype wire

// ===== hdl/rvt_ctrl.sv =====
// ----------------------------------------------------------------------------
// rvt_ctrl: controller of the ray voxel traversal block
// Sequences clipping, per-axis setup, square root and the voxel walk.
// ----------------------------------------------------------------------------
`default_nettype none

module rvt_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire rvt_pkg::status_type status,
   output logic                     busy,
   output rvt_pkg::cmd_type         cmd
);

   rvt_pkg::state_type state_ff, state_in;
   logic [1:0]         axis_ff, axis_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rvt_pkg::ST_IDLE;
         axis_ff  <= '0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      cmd.op   = rvt_pkg::OP_NONE;
      cmd.axis = axis_ff;
      unique case (state_ff)
         rvt_pkg::ST_IDLE: begin
            if (start) begin
               cmd.op   = rvt_pkg::OP_LOAD;
               axis_in  = '0;
               state_in = rvt_pkg::ST_CHECK;
            end
         end
         rvt_pkg::ST_CHECK: begin
            if (status.canc) begin
               if (status.outside) begin
                  state_in = rvt_pkg::ST_MISS;
               end else if (axis_ff == 2'd2) begin
                  state_in = rvt_pkg::ST_BOUND;
               end else begin
                  axis_in = axis_ff + 1'b1;
               end
            end else begin
               state_in = rvt_pkg::ST_AMIN_GO;
            end
         end
         rvt_pkg::ST_AMIN_GO: begin
            cmd.op   = rvt_pkg::OP_MIN_GO;
            state_in = rvt_pkg::ST_AMIN_WAIT;
         end
         rvt_pkg::ST_AMIN_WAIT: begin
            cmd.op = rvt_pkg::OP_MIN_CAP;
            if (status.div_done) state_in = rvt_pkg::ST_AMAX_GO;
         end
         rvt_pkg::ST_AMAX_GO: begin
            cmd.op   = rvt_pkg::OP_MAX_GO;
            state_in = rvt_pkg::ST_AMAX_WAIT;
         end
         rvt_pkg::ST_AMAX_WAIT: begin
            cmd.op = rvt_pkg::OP_MAX_CAP;
            if (status.div_done) begin
               if (axis_ff == 2'd2) begin
                  state_in = rvt_pkg::ST_BOUND;
               end else begin
                  axis_in  = axis_ff + 1'b1;
                  state_in = rvt_pkg::ST_CHECK;
               end
            end
         end
         rvt_pkg::ST_BOUND: begin
            axis_in  = '0;
            state_in = status.empty ? rvt_pkg::ST_MISS : rvt_pkg::ST_DA_GO;
         end
         rvt_pkg::ST_DA_GO: begin
            cmd.op   = rvt_pkg::OP_DA_GO;
            state_in = rvt_pkg::ST_DA_WAIT;
         end
         rvt_pkg::ST_DA_WAIT: begin
            cmd.op = rvt_pkg::OP_DA_CAP;
            if (status.div_done) state_in = rvt_pkg::ST_SQ;
         end
         rvt_pkg::ST_SQ: begin
            cmd.op   = rvt_pkg::OP_SQ;
            state_in = rvt_pkg::ST_POINT;
         end
         rvt_pkg::ST_POINT: begin
            cmd.op   = rvt_pkg::OP_POINT;
            state_in = rvt_pkg::ST_IDX;
         end
         rvt_pkg::ST_IDX: begin
            cmd.op = rvt_pkg::OP_IDX;
            if (status.idx_done) state_in = rvt_pkg::ST_AD_GO;
         end
         rvt_pkg::ST_AD_GO: begin
            cmd.op   = rvt_pkg::OP_AD_GO;
            state_in = status.canc ? rvt_pkg::ST_AD_FIX : rvt_pkg::ST_AD_WAIT;
         end
         rvt_pkg::ST_AD_WAIT: begin
            cmd.op = rvt_pkg::OP_AD_CAP;
            if (status.div_done) state_in = rvt_pkg::ST_AD_FIX;
         end
         rvt_pkg::ST_AD_FIX: begin
            cmd.op = rvt_pkg::OP_AD_FIX;
            if (axis_ff == 2'd2) begin
               state_in = rvt_pkg::ST_SQRT_GO;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = rvt_pkg::ST_DA_GO;
            end
         end
         rvt_pkg::ST_SQRT_GO: begin
            cmd.op   = rvt_pkg::OP_SQRT_GO;
            state_in = rvt_pkg::ST_SQRT_RUN;
         end
         rvt_pkg::ST_SQRT_RUN: begin
            cmd.op = rvt_pkg::OP_SQRT_RUN;
            if (status.sqrt_done) state_in = rvt_pkg::ST_W_SEL;
         end
         rvt_pkg::ST_W_SEL: begin
            cmd.op   = rvt_pkg::OP_W_SEL;
            state_in = rvt_pkg::ST_W_MUL;
         end
         rvt_pkg::ST_W_MUL: begin
            cmd.op   = rvt_pkg::OP_W_MUL;
            state_in = rvt_pkg::ST_W_OUT;
         end
         rvt_pkg::ST_W_OUT: begin
            cmd.op   = rvt_pkg::OP_W_OUT;
            state_in = status.walk_last ? rvt_pkg::ST_IDLE : rvt_pkg::ST_W_SEL;
         end
         rvt_pkg::ST_MISS: begin
            cmd.op   = rvt_pkg::OP_MISS;
            state_in = rvt_pkg::ST_IDLE;
         end
         default: begin
            state_in = rvt_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy = state_ff != rvt_pkg::ST_IDLE;

endmodule

`default_nettype wire
